// File: rtl/core/cfct_pkg.sv
// Shared types and fixed field widths for the CAN frame change tracker.
package cfct_pkg;

   localparam int FRAME_ID_W  = 29;
   localparam int TS_W        = 64;
   localparam int LEN_IN_W    = 7;
   localparam int WORD_NUM_W  = 3;
   localparam int PAYLOAD_W   = 64;
   localparam int DIR_W       = 8;
   localparam int ROW_W       = 20;
   localparam int CNT_W       = 21;
   localparam int REQ_DATA_W  = 168;
   localparam int RSP_DATA_W  = 88;
   localparam int BYTES_PER_WORD = 8;

   localparam logic [CNT_W-1:0] ROW_LIMIT = 21'h100000;

   localparam logic STATUS_ACCEPTED = 1'b0;
   localparam logic STATUS_FULL     = 1'b1;

   typedef struct packed {
      logic active;
      logic differs;
   } word_check_type;

endpackage

// File: rtl/core/cfct_ram.sv
// Single-port-write, single-port-read synchronous RAM with write-to-read forwarding.
module cfct_ram import cfct_pkg::*; #(
   parameter int DEPTH = 8192,
   parameter int WIDTH = 72,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;
   logic [WIDTH-1:0] fwd_data_ff;
   logic             fwd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // A write landing on the same edge as a read of the same entry wins.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff    <= mem_ff[rd_addr];
         fwd_ff      <= wr_en && (wr_addr == rd_addr);
         fwd_data_ff <= wr_data;
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : rdata_ff;

endmodule

// File: rtl/core/cfct_word_check.sv
// Byte-masked compare of one payload word against its stored copy.
module cfct_word_check import cfct_pkg::*; #(
   parameter int MAX_PAYLOAD_BYTES = 64,
   localparam int LEN_W = $clog2(MAX_PAYLOAD_BYTES + 1)
) (
   input  logic [LEN_W-1:0]      len,
   input  logic [WORD_NUM_W-1:0] word,
   input  logic [PAYLOAD_W-1:0]  stored,
   input  logic [PAYLOAD_W-1:0]  fresh,
   output word_check_type        result
);

   logic [BYTES_PER_WORD-1:0] byte_en;
   logic [PAYLOAD_W-1:0]      bit_en;

   always_comb begin
      for (int b = 0; b < BYTES_PER_WORD; b++) begin
         byte_en[b] = {1'b0, word, 3'(b)} < 7'(len);
         bit_en[b*8 +: 8] = {8{byte_en[b]}};
      end
   end

   // A word is active when its first byte lies within the length.
   assign result.active  = byte_en[0];
   assign result.differs = |((stored ^ fresh) & bit_en);

endmodule

// File: rtl/core/can_frame_change_tracker_unit.sv
// Top level of the CAN frame change tracker: compare stage and result register.
// A last-word item passes from the compare stage registers into the result register.
// Throughput: one payload word per cycle; a last word waits in the compare stage while the
// previous result is still held in the output register.
// Reset: a clearing pass over all ID_TABLE_ENTRIES entries wipes the seen flags in the identifier
// RAM; req_tready is low during the pass, csr writes are taken throughout.
module can_frame_change_tracker_unit import cfct_pkg::*; #(
   parameter int ID_TABLE_ENTRIES  = 8192,
   parameter int MAX_PAYLOAD_BYTES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // frame_id[28:0], timestamp_bits[92:29], payload_length[99:93], word_number[102:100],
   // payload_word[166:103], zero pad[167]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // direction_code[7:0]
   input  logic [DIR_W-1:0]      req_tuser,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // row_number[19:0], previous_timestamp[83:20], payload_changed[84], untracked[85],
   // direction_class[86], status[87]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CNT_W-1:0]      csr_data
);

   localparam int IDX_W        = $clog2(ID_TABLE_ENTRIES);
   localparam int WORDS_PER_ID = (MAX_PAYLOAD_BYTES + 7) / 8;
   localparam int SLOT_DEPTH   = ID_TABLE_ENTRIES * WORDS_PER_ID;
   localparam int SLOT_W       = $clog2(SLOT_DEPTH);
   localparam int LEN_W        = $clog2(MAX_PAYLOAD_BYTES + 1);
   localparam int ID_ENTRY_W   = 1 + LEN_W + TS_W;

   // Input field views
   logic [FRAME_ID_W-1:0] in_id;
   logic [TS_W-1:0]       in_ts;
   logic [LEN_IN_W-1:0]   in_len;
   logic [WORD_NUM_W-1:0] in_word;
   logic [PAYLOAD_W-1:0]  in_payload;

   assign in_id      = req_tdata[28:0];
   assign in_ts      = req_tdata[92:29];
   assign in_len     = req_tdata[99:93];
   assign in_word    = req_tdata[102:100];
   assign in_payload = req_tdata[166:103];

   logic             accept;
   logic             tracked_in;
   logic [IDX_W-1:0] idx_in;
   logic [LEN_W-1:0] len_sat_in;
   logic             word_ok_in;
   logic [SLOT_W-1:0] slot_in;

   assign tracked_in = in_id < FRAME_ID_W'(ID_TABLE_ENTRIES);
   assign idx_in     = in_id[IDX_W-1:0];
   assign len_sat_in = (in_len > LEN_IN_W'(MAX_PAYLOAD_BYTES)) ? LEN_W'(MAX_PAYLOAD_BYTES)
                                                               : in_len[LEN_W-1:0];
   assign word_ok_in = {1'b0, in_word} < 4'(WORDS_PER_ID);
   assign slot_in    = SLOT_W'(int'(idx_in) * WORDS_PER_ID + int'(in_word));

   // Compare stage registers
   logic                  s1_valid_ff;
   logic                  s1_tracked_ff;
   logic                  s1_last_ff;
   logic                  s1_dir_ff;
   logic [IDX_W-1:0]      s1_idx_ff;
   logic [SLOT_W-1:0]     s1_slot_ff;
   logic [WORD_NUM_W-1:0] s1_word_ff;
   logic [LEN_W-1:0]      s1_len_ff;
   logic [TS_W-1:0]       s1_ts_ff;
   logic [PAYLOAD_W-1:0]  s1_data_ff;

   // Control state
   logic [CNT_W-1:0] frame_counter_ff, frame_counter_in;
   logic [CNT_W-1:0] capacity_ff;
   logic             mismatch_ff, mismatch_in;
   logic             clear_ff;
   logic [IDX_W-1:0] clear_addr_ff;
   logic             rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic s1_go;
   logic s1_full;
   logic [CNT_W-1:0] cap_eff;

   assign s1_go      = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !clear_ff && (!s1_valid_ff || s1_go);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign cap_eff = (capacity_ff > ROW_LIMIT) ? ROW_LIMIT : capacity_ff;
   assign s1_full = frame_counter_ff >= cap_eff;

   // Memories
   logic                  pay_rd_en;
   logic [PAYLOAD_W-1:0]  pay_rd_data;
   logic                  pay_wr_en;
   logic                  id_wr_en;
   logic [IDX_W-1:0]      id_wr_addr;
   logic [ID_ENTRY_W-1:0] id_wr_data;
   logic [ID_ENTRY_W-1:0] id_rd_data;
   logic                  id_upd;

   assign pay_rd_en = accept && tracked_in && word_ok_in;

   cfct_ram #(
      .DEPTH (SLOT_DEPTH),
      .WIDTH (PAYLOAD_W)
   ) u_payload_ram (
      .clock   (clock),
      .rd_en   (pay_rd_en),
      .rd_addr (slot_in),
      .rd_data (pay_rd_data),
      .wr_en   (pay_wr_en),
      .wr_addr (s1_slot_ff),
      .wr_data (s1_data_ff)
   );

   cfct_ram #(
      .DEPTH (ID_TABLE_ENTRIES),
      .WIDTH (ID_ENTRY_W)
   ) u_id_ram (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (idx_in),
      .rd_data (id_rd_data),
      .wr_en   (id_wr_en),
      .wr_addr (id_wr_addr),
      .wr_data (id_wr_data)
   );

   word_check_type check;

   cfct_word_check #(
      .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
   ) u_word_check (
      .len    (s1_len_ff),
      .word   (s1_word_ff),
      .stored (pay_rd_data),
      .fresh  (s1_data_ff),
      .result (check)
   );

   logic             old_seen;
   logic [LEN_W-1:0] old_len;
   logic [TS_W-1:0]  old_ts;
   logic             known;
   logic             changed;
   logic [TS_W-1:0]  prev_ts;

   assign old_seen = id_rd_data[ID_ENTRY_W-1];
   assign old_len  = id_rd_data[TS_W +: LEN_W];
   assign old_ts   = id_rd_data[TS_W-1:0];

   assign pay_wr_en   = s1_go && !s1_full && s1_tracked_ff && check.active;
   assign mismatch_in = mismatch_ff || (pay_wr_en && check.differs);
   assign known       = s1_tracked_ff && old_seen;
   assign changed     = known && ((old_len != s1_len_ff) || mismatch_in);
   assign prev_ts     = known ? old_ts : s1_ts_ff;
   assign id_upd      = s1_go && s1_last_ff && !s1_full && s1_tracked_ff;

   // The clearing pass owns the identifier RAM write port until it is done.
   always_comb begin
      if (clear_ff) begin
         id_wr_en   = 1'b1;
         id_wr_addr = clear_addr_ff;
         id_wr_data = '0;
      end else begin
         id_wr_en   = id_upd;
         id_wr_addr = s1_idx_ff;
         id_wr_data = {1'b1, s1_len_ff, s1_ts_ff};
      end
   end

   always_comb begin
      frame_counter_in = frame_counter_ff;
      if (s1_go && s1_last_ff && !s1_full) begin
         frame_counter_in = frame_counter_ff + CNT_W'(1);
      end
   end

   always_comb begin
      if (s1_full) begin
         rsp_data_in = {STATUS_FULL, {(RSP_DATA_W-1){1'b0}}};
      end else begin
         rsp_data_in = {STATUS_ACCEPTED, s1_dir_ff, !s1_tracked_ff, changed, prev_ts,
                        frame_counter_ff[ROW_W-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         frame_counter_ff <= '0;
         capacity_ff      <= ROW_LIMIT;
         mismatch_ff      <= 1'b0;
         clear_ff         <= 1'b1;
         clear_addr_ff    <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_go) begin
            s1_valid_ff <= 1'b0;
         end
         frame_counter_ff <= frame_counter_in;
         if (csr_valid) begin
            capacity_ff <= csr_data;
         end
         if (s1_go) begin
            mismatch_ff <= s1_last_ff ? 1'b0 : mismatch_in;
         end
         if (clear_ff) begin
            clear_addr_ff <= clear_addr_ff + IDX_W'(1);
            if (clear_addr_ff == IDX_W'(ID_TABLE_ENTRIES - 1)) begin
               clear_ff <= 1'b0;
            end
         end
         if (s1_go && s1_last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_tracked_ff <= tracked_in;
         s1_last_ff    <= req_tlast;
         s1_dir_ff     <= req_tuser != '0;
         s1_idx_ff     <= idx_in;
         s1_slot_ff    <= slot_in;
         s1_word_ff    <= in_word;
         s1_len_ff     <= len_sat_in;
         s1_ts_ff      <= in_ts;
         s1_data_ff    <= in_payload;
      end
      if (s1_go && s1_last_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_no_work_while_clearing : assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !s1_valid_ff)
      else $error("compare stage busy during the clearing pass");

   a_counter_bounded : assert property (@(posedge clock) disable iff (reset)
      frame_counter_ff <= ROW_LIMIT)
      else $error("frame counter above the row limit");

   a_counter_moves_on_last : assert property (@(posedge clock) disable iff (reset)
      !$stable(frame_counter_ff) |-> $past(s1_go && s1_last_ff && !s1_full))
      else $error("frame counter moved without an accepted last word");

   a_full_result_clean : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff[RSP_DATA_W-1] == STATUS_FULL))
         |-> (rsp_data_ff[RSP_DATA_W-2:0] == '0))
      else $error("full status carries nonzero result fields");

endmodule
